// ----- rtl/core/lkvc_pkg.sv -----
// lkvc_pkg: shared constants and types for the lru key-value cache
// no dependencies; imported by the controller, the datapath and the top level
package lkvc_pkg;

  localparam int Depth = 16;
  localparam int IdxW  = 4;
  localparam int RankW = 4;
  localparam int CntW  = 5;
  localparam int KeyW  = 32;
  localparam int ValW  = 32;

  localparam logic [CntW-1:0] CapReset = CntW'(Depth);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic update;
  } cmd_t;

endpackage

// ----- rtl/core/lkvc_ctrl.sv -----
// lkvc_ctrl: sequencing state machine for the lru key-value cache
// depends on lkvc_pkg; drives datapath commands and the channel handshakes
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MATCH;
      end
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MATCH:  cmd.match  = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_DONE:   out_valid  = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_load_to_match: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.match)
    else $error("compare did not follow a transfer");

  a_match_to_update: assert property (@(posedge clk) disable iff (rst)
    cmd.match |=> cmd.update ##1 out_valid)
    else $error("update or result did not follow compare");

endmodule

// ----- rtl/core/lkvc_datapath.sv -----
// lkvc_datapath: entry storage, parallel key compare and age-rank update
// depends on lkvc_pkg; sequenced by lkvc_ctrl through cmd_t
module lkvc_datapath
  import lkvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic                   cfg_we,
  input  logic [CntW-1:0]        cfg_data,
  input  logic                   op,
  input  logic        [KeyW-1:0] key,
  input  logic        [ValW-1:0] value,
  output logic                   hit,
  output logic        [ValW-1:0] read_value
);

  logic [CntW-1:0]  capacity;
  logic             op_q;
  logic [KeyW-1:0]  key_q;
  logic [ValW-1:0]  val_q;

  logic [KeyW-1:0]  entry_keys   [Depth];
  logic [ValW-1:0]  entry_values [Depth];
  logic [Depth-1:0] entry_valid;
  logic [RankW-1:0] entry_rank   [Depth];
  logic [CntW-1:0]  live_count;

  logic [Depth-1:0] match_vec;
  logic [IdxW-1:0]  match_idx;
  logic             hit_q;
  logic [IdxW-1:0]  hit_idx;

  logic [CntW-1:0]  cap_eff;
  logic             evict_on;
  logic [Depth-1:0] kept;
  logic [IdxW-1:0]  slot;
  logic             ins_we;
  logic [Depth-1:0] valid_next;
  logic [RankW-1:0] rank_next    [Depth];
  logic [CntW-1:0]  live_next;

  // latch the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      key_q <= key;
      val_q <= value;
    end
  end

  // parallel compare, lowest matching entry
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      match_vec[i] = entry_valid[i] && (entry_keys[i] == key_q);
    end
    for (int i = Depth - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IdxW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_q   <= |match_vec;
      hit_idx <= match_idx;
    end
  end

  // effective capacity, eviction and insert slot
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CntW'(1);
    end else if (capacity > CntW'(Depth)) begin
      cap_eff = CntW'(Depth);
    end else begin
      cap_eff = capacity;
    end
    evict_on = live_count >= cap_eff;
    for (int i = 0; i < Depth; i++) begin
      kept[i] = entry_valid[i] &&
                !(evict_on && ({1'b0, entry_rank[i]} >= (cap_eff - CntW'(1))));
    end
    slot = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!kept[i]) slot = IdxW'(i);
    end
    ins_we = !hit_q && (op_q == OP_PUT);
  end

  always_comb begin
    logic [RankW-1:0] hit_rank;
    hit_rank   = entry_rank[hit_idx];
    valid_next = entry_valid;
    rank_next  = entry_rank;
    live_next  = live_count;
    if (hit_q) begin
      for (int i = 0; i < Depth; i++) begin
        if (entry_valid[i] && (entry_rank[i] < hit_rank)) begin
          rank_next[i] = entry_rank[i] + RankW'(1);
        end
      end
      rank_next[hit_idx] = '0;
    end else if (ins_we) begin
      for (int i = 0; i < Depth; i++) begin
        valid_next[i] = kept[i];
        rank_next[i]  = kept[i] ? entry_rank[i] + RankW'(1) : '0;
      end
      valid_next[slot] = 1'b1;
      rank_next[slot]  = '0;
      live_next        = evict_on ? cap_eff : live_count + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CapReset;
      entry_valid <= '0;
      entry_rank  <= '{default: '0};
      live_count  <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (cmd.update) begin
        entry_valid <= valid_next;
        entry_rank  <= rank_next;
        live_count  <= live_next;
      end
    end
  end

  // key and value storage
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (ins_we) begin
        entry_keys[slot]   <= key_q;
        entry_values[slot] <= val_q;
      end else if (hit_q && (op_q == OP_PUT)) begin
        entry_values[hit_idx] <= val_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit        <= hit_q;
      read_value <= (hit_q && (op_q == OP_GET)) ? entry_values[hit_idx] : '0;
    end
  end

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == 32'(live_count))
    else $error("live count disagrees with valid entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= CntW'(Depth))
    else $error("live count above depth");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && hit_q) |=> $stable(live_count) && $stable(entry_valid))
    else $error("hit changed the set of live entries");

endmodule

// ----- rtl/core/lru_key_value_cache_unit.sv -----
// Fully associative 16-entry key-value cache with least-recently-used
// replacement. An item (get or put) passes through transfer in, a parallel
// compare of all keys, a rank and storage update, and the result transfer,
// in the controller's four-state sequence; a new item is accepted only after
// the last result is taken. The user must write capacity on the cfg channel
// only while idle, which the block does not enforce; 0 acts as 1 and values
// above 16 as 16. Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
module lru_key_value_cache_unit
  import lkvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CntW-1:0]        cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic signed [KeyW-1:0] key,
  input  logic signed [ValW-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   hit,
  output logic signed [ValW-1:0] read_value
);

  cmd_t cmd;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkvc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .op         (op),
    .key        (key),
    .value      (value),
    .hit        (hit),
    .read_value (read_value)
  );

endmodule
